>>> design/radar_beam_segment_cleaner_unit_defines.svh
// Assertion helpers shared by the segment cleaner RTL.
`ifndef RADAR_BEAM_SEGMENT_CLEANER_UNIT_DEFINES_SVH
`define RADAR_BEAM_SEGMENT_CLEANER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RBSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RBSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rbsc_pkg.sv
package rbsc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned LEN_CFG_W = 10;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_THR = 3'd0,
    CFG_WIND_MAGIC = 3'd1,
    CFG_MISS_CODE = 3'd2,
    CFG_MIN_LEN = 3'd3,
    CFG_MAX_LEN = 3'd4
  } cfg_reg_e;

  localparam logic signed [SAMPLE_W-1:0] WIDTH_THR_RST = 16'sh0000;
  localparam logic signed [SAMPLE_W-1:0] WIND_MAGIC_RST = 16'shFF83;
  localparam logic signed [SAMPLE_W-1:0] MISS_CODE_RST = 16'sh8000;
  localparam logic [LEN_CFG_W-1:0] MIN_LEN_RST = 10'd3;
  localparam logic [LEN_CFG_W-1:0] MAX_LEN_RST = 10'd20;

  typedef struct packed {
    logic step;
    logic hit;
    logic push;
    logic pop;
  } store_ctrl_t;

  typedef struct packed {
    logic                 has_segment;
    logic [OUT_IDX_W-1:0] seg_first;
    logic [OUT_IDX_W-1:0] seg_final;
    logic                 clean;
    logic                 beam_done;
  } res_t;

endpackage

>>> design/rbsc_seg_store.sv
`include "radar_beam_segment_cleaner_unit_defines.svh"

module rbsc_seg_store import rbsc_pkg::*; #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned WINDOW = 12,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_ctrl_t      ctrl_i,
  input  logic [IDX_W-1:0] first_i,
  input  logic [IDX_W-1:0] final_i,
  input  logic [IDX_W-1:0] len_i,
  input  logic             before_i,
  output logic [IDX_W-1:0] head_first_o,
  output logic [IDX_W-1:0] head_final_o,
  output logic [IDX_W-1:0] head_len_o,
  output logic             head_before_o,
  output logic             head_after_o,
  output logic             head_ripe_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW = $clog2(WINDOW + 1);
  localparam logic [AW:0] WIN_EXT = (AW + 1)'(WINDOW);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [IDX_W-1:0] first_q [DEPTH];
  logic [IDX_W-1:0] final_q [DEPTH];
  logic [IDX_W-1:0] len_q [DEPTH];
  logic             before_q [DEPTH];
  logic             after_q [DEPTH];
  logic [AW-1:0]    age_q [DEPTH];

  logic [PW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl_i.push && (tail_q == PW'(i))) begin
        first_q[i] <= first_i;
        final_q[i] <= final_i;
        len_q[i] <= len_i;
        before_q[i] <= before_i;
        after_q[i] <= 1'b0;
        age_q[i] <= '0;
      end else if (ctrl_i.step) begin
        after_q[i] <= after_q[i] | ctrl_i.hit;
        age_q[i] <= age_q[i] + 1'b1;
      end
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
    end
    count_d = count_q + CNT_W'(ctrl_i.push) - CNT_W'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      count_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_first_o = first_q[head_q];
  assign head_final_o = final_q[head_q];
  assign head_len_o = len_q[head_q];
  assign head_before_o = before_q[head_q];
  assign head_after_o = after_q[head_q];
  assign head_ripe_o = ((AW + 1)'(age_q[head_q]) + 1'b1) >= WIN_EXT;
  assign count_o = count_q;

  `RBSC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "store count over depth")
  `RBSC_ASSERT_IMP(a_pop_nonempty, ctrl_i.pop, count_q != '0, "pop from empty store")
  `RBSC_ASSERT_IMP(a_push_room, ctrl_i.push, (count_q < CNT_W'(DEPTH)) || ctrl_i.pop,
                   "push into full store")

endmodule

>>> design/radar_beam_segment_cleaner_unit.sv
// Output: a result is registered at the edge that accepts the bin releasing it.
// One bin per cycle unless in_stall_o; a 2-entry output buffer absorbs output stall.
// End of beam: pending segments drain one per cycle unless stalled, input held meanwhile.
// Reset: control state cleared, config registers back to their defaults.
`include "radar_beam_segment_cleaner_unit_defines.svh"

module radar_beam_segment_cleaner_unit import rbsc_pkg::*; #(
  parameter int unsigned BEAM_BINS = 1024,
  parameter int unsigned WINDOW = 12,
  parameter int unsigned MAX_PENDING = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] refl_i,
  input  logic signed [SAMPLE_W-1:0] width_i,
  input  logic signed [SAMPLE_W-1:0] velocity_i,
  input  logic                       last_bin_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       has_segment_o,
  output logic [OUT_IDX_W-1:0]       seg_first_o,
  output logic [OUT_IDX_W-1:0]       seg_final_o,
  output logic                       clean_o,
  output logic                       beam_done_o
);

  localparam int unsigned BW = $clog2(BEAM_BINS);
  localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1);
  localparam int unsigned CMP_W = (BW > LEN_CFG_W) ? BW : LEN_CFG_W;
  localparam logic [BW-1:0] BIN_LAST = BW'(BEAM_BINS - 1);
  localparam logic [BW:0] BINS_EXT = (BW + 1)'(BEAM_BINS);
  localparam logic [CNT_W-1:0] PEND_MAX = CNT_W'(MAX_PENDING);

  logic signed [SAMPLE_W-1:0] width_thr_q, wind_magic_q, miss_code_q;
  logic [LEN_CFG_W-1:0]       min_len_q, max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_thr_q <= WIDTH_THR_RST;
      wind_magic_q <= WIND_MAGIC_RST;
      miss_code_q <= MISS_CODE_RST;
      min_len_q <= MIN_LEN_RST;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WIDTH_THR: width_thr_q <= cfg_data_i;
        CFG_WIND_MAGIC: wind_magic_q <= cfg_data_i;
        CFG_MISS_CODE: miss_code_q <= cfg_data_i;
        CFG_MIN_LEN: min_len_q <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_MAX_LEN: max_len_q <= cfg_data_i[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [BW-1:0]     bin_q, bin_d, open_start_q, open_start_d;
  logic              in_seg_q, in_seg_d;
  logic [WINDOW-1:0] hist_q, hist_d;
  logic              drain_q, drain_d;
  logic              out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  res_t              out_q, skid_q, res;

  logic              in_acc, match, refl_ge, refl_gt;
  logic              ripe, seg_close, drain_go, res_push;
  logic [BW-1:0]     close_final, close_len;
  logic [CNT_W-1:0]  cnt_end;

  store_ctrl_t       st_ctrl;
  logic [BW-1:0]     hd_first, hd_final, hd_len;
  logic              hd_before, hd_after, hd_ripe;
  logic [CNT_W-1:0]  st_count;

  logic              res_after;
  logic [CMP_W-1:0]  res_len;

  assign in_stall_o = skid_vld_q | drain_q;
  assign in_acc = in_valid_i & ~in_stall_o;

  assign match = (width_i == width_thr_q) && (velocity_i == wind_magic_q);
  assign refl_ge = refl_i >= miss_code_q;
  assign refl_gt = refl_i > miss_code_q;

  assign ripe = in_acc && !last_bin_i && (st_count != '0) && hd_ripe;
  assign seg_close = in_acc && in_seg_q && (!match || last_bin_i);
  assign drain_go = drain_q && !skid_vld_q;

  always_comb begin
    if (last_bin_i) begin
      close_final = bin_q;
    end else begin
      close_final = (bin_q == '0) ? BIN_LAST : bin_q - 1'b1;
    end
    if (close_final >= open_start_q) begin
      close_len = BW'({1'b0, close_final} - {1'b0, open_start_q});
    end else begin
      close_len = BW'({1'b0, close_final} + BINS_EXT - {1'b0, open_start_q});
    end
  end

  always_comb begin
    st_ctrl.step = in_acc;
    st_ctrl.hit = refl_ge;
    st_ctrl.pop = ripe | drain_go;
    st_ctrl.push = seg_close && ((st_count - CNT_W'(ripe)) < PEND_MAX);
  end

  assign cnt_end = st_count + CNT_W'(st_ctrl.push);

  rbsc_seg_store #(
    .IDX_W(BW),
    .WINDOW(WINDOW),
    .DEPTH(MAX_PENDING)
  ) u_store (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(st_ctrl),
    .first_i(open_start_q),
    .final_i(close_final),
    .len_i(close_len),
    .before_i(|hist_q),
    .head_first_o(hd_first),
    .head_final_o(hd_final),
    .head_len_o(hd_len),
    .head_before_o(hd_before),
    .head_after_o(hd_after),
    .head_ripe_o(hd_ripe),
    .count_o(st_count)
  );

  always_comb begin
    res_after = hd_after | (ripe & refl_ge);
    res_len = CMP_W'(hd_len);
    res.has_segment = 1'b1;
    res.seg_first = OUT_IDX_W'(hd_first);
    res.seg_final = OUT_IDX_W'(hd_final);
    res.clean = ((res_len >= CMP_W'(min_len_q)) && !hd_before && !res_after) ||
                (res_len >= CMP_W'(max_len_q));
    res.beam_done = drain_go && (st_count == CNT_W'(1));
    res_push = ripe | drain_go;
    if (in_acc && last_bin_i && (cnt_end == '0)) begin
      res = '0;
      res.beam_done = 1'b1;
      res_push = 1'b1;
    end
  end

  always_comb begin
    bin_d = bin_q;
    in_seg_d = in_seg_q;
    open_start_d = open_start_q;
    hist_d = hist_q;
    drain_d = drain_q;
    if (in_acc) begin
      if (last_bin_i) begin
        bin_d = '0;
        in_seg_d = 1'b0;
        open_start_d = '0;
        hist_d = '0;
        drain_d = (cnt_end != '0);
      end else begin
        bin_d = (bin_q == BIN_LAST) ? '0 : bin_q + 1'b1;
        hist_d = WINDOW'({hist_q, refl_gt});
        if (!in_seg_q) begin
          if (match) begin
            in_seg_d = 1'b1;
            open_start_d = bin_q;
          end
        end else if (!match) begin
          in_seg_d = 1'b0;
        end
      end
    end else if (drain_go && (st_count == CNT_W'(1))) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      in_seg_q <= 1'b0;
      open_start_q <= '0;
      hist_q <= '0;
      drain_q <= 1'b0;
    end else begin
      bin_q <= bin_d;
      in_seg_q <= in_seg_d;
      open_start_q <= open_start_d;
      hist_q <= hist_d;
      drain_q <= drain_d;
    end
  end

  // Output register with one skid entry.
  logic pop_out, load_out, load_skid, from_skid;

  assign pop_out = out_vld_q & ~out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out = 1'b0;
    load_skid = 1'b0;
    from_skid = 1'b0;
    if (skid_vld_q) begin
      if (pop_out) begin
        from_skid = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (res_push) begin
      if (!out_vld_q || pop_out) begin
        load_out = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (pop_out) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end else if (from_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign has_segment_o = out_q.has_segment;
  assign seg_first_o = out_q.seg_first;
  assign seg_final_o = out_q.seg_final;
  assign clean_o = out_q.clean;
  assign beam_done_o = out_q.beam_done;

  `RBSC_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry without output entry")
  `RBSC_ASSERT_IMP(a_drain_nonempty, drain_q, st_count != '0, "drain with empty store")
  `RBSC_ASSERT_NXT(a_beam_reset, in_acc && last_bin_i, (bin_q == '0) && !in_seg_q,
                   "beam state not cleared after last bin")

endmodule

>>> verif/radar_beam_segment_cleaner_unit_checker.sv
module radar_beam_segment_cleaner_unit_checker import rbsc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] refl_i,
  input  logic signed [SAMPLE_W-1:0] width_i,
  input  logic signed [SAMPLE_W-1:0] velocity_i,
  input  logic                       last_bin_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       has_segment_i,
  input  logic [OUT_IDX_W-1:0]       seg_first_i,
  input  logic [OUT_IDX_W-1:0]       seg_final_i,
  input  logic                       clean_i,
  input  logic                       beam_done_i,
  output int                         fail_cnt_o,
  output int                         reports_due_o
);

  localparam int unsigned WINDOW = 12;
  localparam int unsigned MAX_PEND = 8;

  typedef struct {
    logic [OUT_IDX_W-1:0] first_idx;
    logic [OUT_IDX_W-1:0] last_idx;
    logic [OUT_IDX_W-1:0] span;
    logic                 before_hit;
    logic                 after_hit;
    int unsigned          age;
  } closed_seg_t;

  logic signed [SAMPLE_W-1:0] width_thr;
  logic signed [SAMPLE_W-1:0] magic_vel;
  logic signed [SAMPLE_W-1:0] miss_code;
  logic [LEN_CFG_W-1:0]       min_len;
  logic [LEN_CFG_W-1:0]       max_len;

  logic [OUT_IDX_W-1:0] bin_idx;
  logic [OUT_IDX_W-1:0] run_start;
  logic                 in_run;
  logic [WINDOW-1:0]    refl_hist;
  closed_seg_t          waiting_segs[$];
  res_t                 reports_due[$];
  int                   mismatches;

  function automatic res_t segment_report(closed_seg_t s, logic done);
    res_t r;
    r.has_segment = 1'b1;
    r.seg_first = s.first_idx;
    r.seg_final = s.last_idx;
    r.clean = (s.span >= min_len && !s.before_hit && !s.after_hit) || s.span >= max_len;
    r.beam_done = done;
    return r;
  endfunction

  task automatic clear_beam();
    bin_idx = '0;
    run_start = '0;
    in_run = 1'b0;
    refl_hist = '0;
    waiting_segs.delete();
  endtask

  task automatic predict_bin(input logic signed [SAMPLE_W-1:0] refl,
                             input logic signed [SAMPLE_W-1:0] wid,
                             input logic signed [SAMPLE_W-1:0] vel,
                             input logic last);
    closed_seg_t kept[$];
    closed_seg_t s;
    res_t        empty_rep;
    logic        hit;
    hit = (wid == width_thr) && (vel == magic_vel);

    // this bin is part of the after-window of every waiting segment
    foreach (waiting_segs[i]) begin
      waiting_segs[i].age = waiting_segs[i].age + 1;
      if (refl >= miss_code) waiting_segs[i].after_hit = 1'b1;
    end
    foreach (waiting_segs[i]) begin
      if (waiting_segs[i].age >= WINDOW && !last) begin
        reports_due.insert(reports_due.size(), segment_report(waiting_segs[i], 1'b0));
      end else begin
        kept.insert(kept.size(), waiting_segs[i]);
      end
    end
    waiting_segs = kept;

    if (!in_run) begin
      if (hit) begin
        in_run = 1'b1;
        run_start = bin_idx;
      end
    end else if (!hit || last) begin
      in_run = 1'b0;
      s.first_idx = run_start;
      s.last_idx = last ? bin_idx : bin_idx - 1'b1;
      s.span = s.last_idx - s.first_idx;
      s.before_hit = |refl_hist;
      s.after_hit = 1'b0;
      s.age = 0;
      if (waiting_segs.size() < MAX_PEND) waiting_segs.insert(waiting_segs.size(), s);
    end

    refl_hist = {refl_hist[WINDOW-2:0], refl > miss_code};
    bin_idx = bin_idx + 1'b1;

    if (last) begin
      if (waiting_segs.size() == 0) begin
        empty_rep = '0;
        empty_rep.beam_done = 1'b1;
        reports_due.insert(reports_due.size(), empty_rep);
      end else begin
        foreach (waiting_segs[i]) begin
          reports_due.insert(reports_due.size(),
                             segment_report(waiting_segs[i], i == waiting_segs.size() - 1));
        end
      end
      clear_beam();
    end
  endtask

  task automatic check_field(input string name, input logic [OUT_IDX_W-1:0] want,
                             input logic [OUT_IDX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (reports_due.size() == 0) begin
      $error("result with nothing pending: has_segment %0d first %0d final %0d clean %0d done %0d",
             got.has_segment, got.seg_first, got.seg_final, got.clean, got.beam_done);
      mismatches++;
    end else begin
      want = reports_due.pop_front();
      check_field("has_segment", want.has_segment, got.has_segment);
      check_field("seg_first", want.seg_first, got.seg_first);
      check_field("seg_final", want.seg_final, got.seg_final);
      check_field("clean", want.clean, got.clean);
      check_field("beam_done", want.beam_done, got.beam_done);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_thr = WIDTH_THR_RST;
      magic_vel = WIND_MAGIC_RST;
      miss_code = MISS_CODE_RST;
      min_len = MIN_LEN_RST;
      max_len = MAX_LEN_RST;
      clear_beam();
      reports_due.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      reports_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH_THR: width_thr = cfg_data_i;
          CFG_WIND_MAGIC: magic_vel = cfg_data_i;
          CFG_MISS_CODE: miss_code = cfg_data_i;
          CFG_MIN_LEN: min_len = cfg_data_i[LEN_CFG_W-1:0];
          CFG_MAX_LEN: max_len = cfg_data_i[LEN_CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_bin(refl_i, width_i, velocity_i, last_bin_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result({has_segment_i, seg_first_i, seg_final_i, clean_i, beam_done_i});
      end
      fail_cnt_o <= mismatches;
      reports_due_o <= reports_due.size();
    end
  end

endmodule

>>> verif/radar_beam_segment_cleaner_unit_tb.sv
module radar_beam_segment_cleaner_unit_tb import rbsc_pkg::*; ();

  localparam int STALL_LIMIT = 2000;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx = '0;
  logic [SAMPLE_W-1:0]        cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] bin_refl = '0;
  logic signed [SAMPLE_W-1:0] bin_width = '0;
  logic signed [SAMPLE_W-1:0] bin_vel = '0;
  logic                       bin_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       has_segment;
  logic [OUT_IDX_W-1:0]       seg_first;
  logic [OUT_IDX_W-1:0]       seg_final;
  logic                       clean;
  logic                       beam_done;
  int                         fail_cnt;
  int                         reports_due;

  logic                       quiet = 1'b0;
  int                         hold_left = 0;
  int                         hold_draw;
  int                         idle_cycles = 0;

  logic signed [SAMPLE_W-1:0] thr_now = WIDTH_THR_RST;
  logic signed [SAMPLE_W-1:0] magic_now = WIND_MAGIC_RST;
  logic signed [SAMPLE_W-1:0] zmiss_now = MISS_CODE_RST;

  radar_beam_segment_cleaner_unit dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .refl_i(bin_refl),
    .width_i(bin_width),
    .velocity_i(bin_vel),
    .last_bin_i(bin_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .has_segment_o(has_segment),
    .seg_first_o(seg_first),
    .seg_final_o(seg_final),
    .clean_o(clean),
    .beam_done_o(beam_done)
  );

  radar_beam_segment_cleaner_unit_checker chk (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_i(in_stall),
    .refl_i(bin_refl),
    .width_i(bin_width),
    .velocity_i(bin_vel),
    .last_bin_i(bin_last),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .has_segment_i(has_segment),
    .seg_first_i(seg_first),
    .seg_final_i(seg_final),
    .clean_i(clean),
    .beam_done_i(beam_done),
    .fail_cnt_o(fail_cnt),
    .reports_due_o(reports_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold_draw = quiet ? 0 : $urandom_range(0, 4);
      out_stall <= hold_draw != 0;
      hold_left <= hold_draw;
    end else if (hold_left != 0) begin
      out_stall <= hold_left > 1;
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_bin(input logic signed [SAMPLE_W-1:0] r, input logic signed [SAMPLE_W-1:0] w,
                          input logic signed [SAMPLE_W-1:0] v, input logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    bin_refl <= r;
    bin_width <= w;
    bin_vel <= v;
    bin_last <= l;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [SAMPLE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // below / at / anywhere relative to the missing code
  function automatic logic signed [SAMPLE_W-1:0] pick_refl(input int below_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < below_pct && zmiss_now != S_MIN) begin
      return S_MIN + 16'($urandom_range(0, int'(zmiss_now) + 32767));
    end
    if (roll < below_pct + 10) return zmiss_now;
    return 16'($urandom);
  endfunction

  task automatic run_beam(input int nbins, input int below_pct);
    int                         run_left;
    int                         gap_left;
    logic                       hit;
    logic signed [SAMPLE_W-1:0] w;
    logic signed [SAMPLE_W-1:0] v;
    run_left = 0;
    gap_left = $urandom_range(0, 3);
    quiet <= ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nbins; i++) begin
      if (run_left == 0 && gap_left == 0) begin
        run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 6);
        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
      end
      hit = run_left != 0;
      if (run_left != 0) run_left--;
      else if (gap_left != 0) gap_left--;
      if (hit) begin
        w = thr_now;
        v = magic_now;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            w = thr_now;
            v = magic_now ^ (16'd1 << $urandom_range(0, 15));
          end
          1: begin
            w = 16'($urandom);
            v = magic_now;
          end
          default: begin
            w = 16'($urandom);
            v = 16'($urandom);
          end
        endcase
      end
      send_bin(pick_refl(below_pct), w, v, i == nbins - 1);
    end
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] thr;
    logic signed [SAMPLE_W-1:0] magic;
    logic signed [SAMPLE_W-1:0] zmiss;
    logic [SAMPLE_W-1:0]        min_word;
    logic [SAMPLE_W-1:0]        max_word;
    int                         phase_bins;
    int                         nbins;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // segment opening on the final bin is dropped
    send_bin(S_MAX, WIDTH_THR_RST, WIND_MAGIC_RST, 1'b1);
    send_bin(S_MIN, S_MIN, S_MAX, 1'b0);
    repeat (3) send_bin(S_MIN, WIDTH_THR_RST, WIND_MAGIC_RST, 1'b0);
    send_bin(S_MAX, S_MAX, S_MIN, 1'b0);
    send_bin(S_MIN, WIDTH_THR_RST, WIND_MAGIC_RST, 1'b0);
    send_bin(S_MIN, WIDTH_THR_RST, 16'sd0, 1'b0);
    repeat (10) send_bin(S_MIN, WIND_MAGIC_RST, WIDTH_THR_RST, 1'b0);
    repeat (3) send_bin(S_MIN, WIDTH_THR_RST, WIND_MAGIC_RST, 1'b0);
    send_bin(S_MIN, WIDTH_THR_RST, WIND_MAGIC_RST, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          thr = S_MIN;
          magic = S_MAX;
          zmiss = 16'sd0;
          min_word = 16'hFC00;
          max_word = 16'hABFF;
        end
        1: begin
          thr = S_MAX;
          magic = S_MIN;
          zmiss = S_MAX;
          min_word = 16'h57FF;
          max_word = 16'hF400;
        end
        2: begin
          thr = WIDTH_THR_RST;
          magic = WIND_MAGIC_RST;
          zmiss = S_MIN;
          min_word = 16'd3;
          max_word = 16'd20;
        end
        default: begin
          thr = 16'($urandom);
          magic = 16'($urandom);
          zmiss = 16'($urandom);
          min_word = (16'($urandom) & 16'hFC00) | 16'($urandom_range(0, 12));
          max_word = (16'($urandom) & 16'hFC00) | 16'($urandom_range(0, 40));
        end
      endcase
      drain_results();
      write_reg(CFG_WIDTH_THR, thr);
      write_reg(CFG_WIND_MAGIC, magic);
      write_reg(CFG_MISS_CODE, zmiss);
      write_reg(CFG_MIN_LEN, min_word);
      write_reg(CFG_MAX_LEN, max_word);
      cfg_we <= 1'b0;
      thr_now = thr;
      magic_now = magic;
      zmiss_now = zmiss;

      phase_bins = 0;
      while (phase_bins < 50) begin
        nbins = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        run_beam(nbins, $urandom_range(0, 90));
        phase_bins += nbins;
      end
    end

    drain_results();
    if (fail_cnt == 0 && reports_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> radar_beam_segment_cleaner_unit.f
+incdir+design
design/rbsc_pkg.sv
design/rbsc_seg_store.sv
design/radar_beam_segment_cleaner_unit.sv
verif/radar_beam_segment_cleaner_unit_checker.sv
verif/radar_beam_segment_cleaner_unit_tb.sv
